// ===== hdl/dfd_pkg.sv =====
// Shared constants, types and helpers for the decimated feedback delay core.
package dfd_pkg;

  // Ring buffer geometry
  localparam int BUFFER_DEPTH = 65536;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);

  // Sample and coefficient formats
  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 16;
  localparam int FRAC_BITS  = 14;
  localparam int PROD_W     = SAMPLE_W + GAIN_W;
  localparam int SCALED_W   = PROD_W - FRAC_BITS;
  localparam int WIDE_W     = SAMPLE_W + 3;

  // Register field widths
  localparam int DELAY_W     = 16;
  localparam int SHIFT_W     = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int MASK_W      = 32;

  // Output queue sizing
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
  localparam int OCC_W      = FIFO_CNT_W + 1;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [PROD_W-1:0]   ROUND_BIAS = PROD_W'(1) <<< (FRAC_BITS - 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ADDR_W-1:0]          addr_t;

  // Register indexes on the configuration channel
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DELAY = 2'd0,
    CFG_SHIFT = 2'd1,
    CFG_GAIN  = 2'd2
  } cfg_index_t;

  // Clamp a widened difference to the signed sample range
  function automatic sample_t sat_sample(input logic signed [WIDE_W-1:0] v);
    sample_t res;
    if (v > WIDE_W'(SAMPLE_MAX)) begin
      res = SAMPLE_MAX;
    end else if (v < WIDE_W'(SAMPLE_MIN)) begin
      res = SAMPLE_MIN;
    end else begin
      res = v[SAMPLE_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hdl/decimated_feedback_delay_core.sv =====
// Feedback comb filter with a coarse read tap over a block RAM ring buffer.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one signed Q1.23 sample per word.
//   m_tvalid/m_tready/m_tdata return one saturated Q1.23 sample per input word,
//   in order. cfg_valid/cfg_ready/cfg_index/cfg_data write the delay in samples
//   (index 0), the number of cleared low read address bits (index 1) and the
//   Q2.14 feedback gain (index 2); cfg_ready is high whenever rst is low. Write
//   registers only while no word is in flight.
// Path: an accepted word passes the tap-stage and multiply-stage registers
//   and is then written to the output queue, which raises m_tvalid.
// Throughput: one word per cycle while the queue has room. When the quantized
//   tap address hits a sample still in the two stages after the RAM read,
//   input is held until that sample reaches the write-back stage, so a tap
//   of one or two samples stalls input; the read-modify-write loop through
//   the single RAM is the limit; a tap on the last-stage sample is forwarded.
// Reset: clears the write pointer, registers and pipeline; s_tready and
//   cfg_ready stay low while rst is high. The RAM is not swept; entries above
//   the write pointer read as zero until the pointer first wraps.
// Stall: a four-word output queue absorbs m_tready low; s_tready drops once
//   the queue plus words in flight fill it.
module decimated_feedback_delay_core (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [dfd_pkg::SAMPLE_W-1:0]         s_tdata,    // [23:0] sample_in
  // Output stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [dfd_pkg::SAMPLE_W-1:0]         m_tdata,    // [23:0] sample_out
  // Configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dfd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [dfd_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // Configuration registers
  logic [dfd_pkg::DELAY_W-1:0]       delay_samples;
  logic [dfd_pkg::SHIFT_W-1:0]       decimate_shift;
  logic signed [dfd_pkg::GAIN_W-1:0] feedback_gain;

  // Write pointer and wrap flag
  dfd_pkg::addr_t wp;
  logic           wrapped;

  // Ring buffer
  dfd_pkg::sample_t store [dfd_pkg::BUFFER_DEPTH];
  dfd_pkg::sample_t rdata;

  // Issue stage signals
  logic [dfd_pkg::MASK_W-1:0] mask_wide;
  dfd_pkg::addr_t             coarse_mask;
  dfd_pkg::addr_t             rd_addr;
  logic                       tap_written;
  logic                       self_hit;
  logic                       fwd_hit;
  logic                       hazard;
  logic [dfd_pkg::OCC_W-1:0]  occupancy;
  logic                       accept;

  // Tap stage registers
  logic             v1;
  dfd_pkg::sample_t x1;
  dfd_pkg::addr_t   w1;
  logic             self1;
  logic             fwd1;
  logic             written1;
  dfd_pkg::sample_t fwd_data1;
  dfd_pkg::sample_t tap1;
  dfd_pkg::sample_t y1;

  // Multiply stage registers
  logic             v2;
  dfd_pkg::sample_t x2;
  dfd_pkg::addr_t   w2;
  dfd_pkg::sample_t y2;

  // Write-back stage registers
  logic                               v3;
  dfd_pkg::sample_t                   x3;
  dfd_pkg::addr_t                     w3;
  logic signed [dfd_pkg::PROD_W-1:0]  prod3;
  logic signed [dfd_pkg::PROD_W-1:0]  biased3;
  logic signed [dfd_pkg::SCALED_W-1:0] scaled3;
  dfd_pkg::sample_t                   stored3;

  // Output queue
  dfd_pkg::sample_t                fifo_mem [dfd_pkg::FIFO_DEPTH];
  logic [dfd_pkg::FIFO_PTR_W-1:0]  head;
  logic [dfd_pkg::FIFO_PTR_W-1:0]  tail;
  logic [dfd_pkg::FIFO_CNT_W-1:0]  fifo_count;
  logic                            push;
  logic                            pop;

  // Accept configuration writes outside reset
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples  <= '0;
      decimate_shift <= '0;
      feedback_gain  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dfd_pkg::cfg_index_t'(cfg_index))
        dfd_pkg::CFG_DELAY: delay_samples  <= cfg_data[dfd_pkg::DELAY_W-1:0];
        dfd_pkg::CFG_SHIFT: decimate_shift <= cfg_data[dfd_pkg::SHIFT_W-1:0];
        dfd_pkg::CFG_GAIN:  feedback_gain  <= $signed(cfg_data[dfd_pkg::GAIN_W-1:0]);
        default: ;
      endcase
    end
  end

  // Compute the quantized tap address and check it against words in flight
  always_comb begin
    mask_wide   = {{(dfd_pkg::MASK_W-dfd_pkg::ADDR_W){1'b0}}, {dfd_pkg::ADDR_W{1'b1}}}
                  << decimate_shift;
    coarse_mask = mask_wide[dfd_pkg::ADDR_W-1:0];
    rd_addr     = (wp - dfd_pkg::ADDR_W'(delay_samples)) & coarse_mask;
    tap_written = wrapped || (rd_addr < wp);
    self_hit    = (rd_addr == wp);
    fwd_hit     = v3 && (rd_addr == w3);
    hazard      = (v1 && (rd_addr == w1)) || (v2 && (rd_addr == w2));
    occupancy   = dfd_pkg::OCC_W'(fifo_count) + dfd_pkg::OCC_W'(v1) + dfd_pkg::OCC_W'(v2);
  end

  assign s_tready = !rst && (occupancy < dfd_pkg::OCC_W'(dfd_pkg::FIFO_DEPTH)) && !hazard;
  assign accept   = s_tvalid && s_tready;

  // Advance the write pointer and note the first wrap
  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
    end else if (accept) begin
      wp <= wp + dfd_pkg::ADDR_W'(1);
      if (wp == {dfd_pkg::ADDR_W{1'b1}}) begin
        wrapped <= 1'b1;
      end
    end
  end

  // Read the tap; write back the stored value from the last stage
  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (v3) begin
      store[w3] <= stored3;
    end
  end

  // Tap stage: capture the word and its tap source
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x1        <= $signed(s_tdata);
      w1        <= wp;
      self1     <= self_hit;
      fwd1      <= fwd_hit;
      written1  <= tap_written;
      fwd_data1 <= stored3;
    end
  end

  // Select the tap and form the output sample
  always_comb begin
    priority if (self1) begin
      tap1 = x1;
    end else if (fwd1) begin
      tap1 = fwd_data1;
    end else if (written1) begin
      tap1 = rdata;
    end else begin
      tap1 = '0;
    end
    y1 = dfd_pkg::sat_sample(dfd_pkg::WIDE_W'(x1) - dfd_pkg::WIDE_W'(tap1));
  end

  // Multiply stage: hold the output sample
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    x2 <= x1;
    w2 <= w1;
    y2 <= y1;
  end

  // Write-back stage: register the feedback product
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    x3    <= x2;
    w3    <= w2;
    prod3 <= dfd_pkg::PROD_W'(feedback_gain) * dfd_pkg::PROD_W'(y2);
  end

  // Round the Q3.37 product to Q3.23 and subtract it from the input, saturating to Q1.23
  always_comb begin
    biased3 = prod3 + dfd_pkg::ROUND_BIAS;
    scaled3 = biased3[dfd_pkg::PROD_W-1:dfd_pkg::FRAC_BITS];
    stored3 = dfd_pkg::sat_sample(dfd_pkg::WIDE_W'(x3) - dfd_pkg::WIDE_W'(scaled3));
  end

  // Queue output words
  assign push     = v2;
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (fifo_count != '0);
  assign m_tdata  = fifo_mem[head];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[tail] <= y2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        tail <= tail + dfd_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        head <= head + dfd_pkg::FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        fifo_count <= fifo_count + dfd_pkg::FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        fifo_count <= fifo_count - dfd_pkg::FIFO_CNT_W'(1);
      end
    end
  end

  // Words in flight plus queued words never exceed the queue
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    occupancy <= dfd_pkg::OCC_W'(dfd_pkg::FIFO_DEPTH))
    else $error("output queue overcommitted");

  // A push always finds room in the queue
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> ((fifo_count < dfd_pkg::FIFO_CNT_W'(dfd_pkg::FIFO_DEPTH)) || pop))
    else $error("push into full output queue");

  // The wrap flag rises only as the pointer returns to zero
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    $rose(wrapped) |-> (wp == '0))
    else $error("wrap flag set away from pointer wrap");

  // A forwarded tap never coincides with the current-write tap
  a_fwd_self: assert property (@(posedge clk) disable iff (rst)
    (v1 && fwd1) |-> !self1)
    else $error("forward and self tap both selected");

endmodule
